### hdl/a2m_pkg.sv
`default_nettype none

package a2m_pkg;

	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] CAPACITY_RESET = 16'd256;

	localparam logic [1:0] SYM_DOT = 2'd0;
	localparam logic [1:0] SYM_DASH = 2'd1;
	localparam logic [1:0] SYM_LGAP = 2'd2;
	localparam logic [1:0] SYM_WGAP = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SPACE = 2'd1;
	localparam logic [1:0] KIND_CODE = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic start_of_text;
	} in_word_t;

	typedef struct packed {
		logic [1:0] symbol;
		logic last;
		logic [15:0] symbols_written;
	} out_word_t;

	// Code pattern is left-justified: bit 5 is the first symbol, 1 means dash.
	typedef struct packed {
		logic [2:0] len;
		logic [5:0] pat;
	} code_t;

	typedef struct packed {
		logic start;
		logic [1:0] kind;
		code_t code;
	} item_t;

	function automatic code_t code_lookup(input logic [7:0] ch_in);
		logic [7:0] ch;
		code_t c;
		ch = ch_in;
		if (ch >= "a" && ch <= "z") begin
			ch = ch - 8'd32;
		end
		unique case (ch)
			"A": c = '{len: 3'd2, pat: 6'b010000};
			"B": c = '{len: 3'd4, pat: 6'b100000};
			"C": c = '{len: 3'd4, pat: 6'b101000};
			"D": c = '{len: 3'd3, pat: 6'b100000};
			"E": c = '{len: 3'd1, pat: 6'b000000};
			"F": c = '{len: 3'd4, pat: 6'b001000};
			"G": c = '{len: 3'd3, pat: 6'b110000};
			"H": c = '{len: 3'd4, pat: 6'b000000};
			"I": c = '{len: 3'd2, pat: 6'b000000};
			"J": c = '{len: 3'd4, pat: 6'b011100};
			"K": c = '{len: 3'd3, pat: 6'b101000};
			"L": c = '{len: 3'd4, pat: 6'b010000};
			"M": c = '{len: 3'd2, pat: 6'b110000};
			"N": c = '{len: 3'd2, pat: 6'b100000};
			"O": c = '{len: 3'd3, pat: 6'b111000};
			"P": c = '{len: 3'd4, pat: 6'b011000};
			"Q": c = '{len: 3'd4, pat: 6'b110100};
			"R": c = '{len: 3'd3, pat: 6'b010000};
			"S": c = '{len: 3'd3, pat: 6'b000000};
			"T": c = '{len: 3'd1, pat: 6'b100000};
			"U": c = '{len: 3'd3, pat: 6'b001000};
			"V": c = '{len: 3'd4, pat: 6'b000100};
			"W": c = '{len: 3'd3, pat: 6'b011000};
			"X": c = '{len: 3'd4, pat: 6'b100100};
			"Y": c = '{len: 3'd4, pat: 6'b101100};
			"Z": c = '{len: 3'd4, pat: 6'b110000};
			"0": c = '{len: 3'd5, pat: 6'b111110};
			"1": c = '{len: 3'd5, pat: 6'b011110};
			"2": c = '{len: 3'd5, pat: 6'b001110};
			"3": c = '{len: 3'd5, pat: 6'b000110};
			"4": c = '{len: 3'd5, pat: 6'b000010};
			"5": c = '{len: 3'd5, pat: 6'b000000};
			"6": c = '{len: 3'd5, pat: 6'b100000};
			"7": c = '{len: 3'd5, pat: 6'b110000};
			"8": c = '{len: 3'd5, pat: 6'b111000};
			"9": c = '{len: 3'd5, pat: 6'b111100};
			".": c = '{len: 3'd6, pat: 6'b010101};
			",": c = '{len: 3'd6, pat: 6'b110011};
			"?": c = '{len: 3'd6, pat: 6'b001100};
			"!": c = '{len: 3'd6, pat: 6'b101011};
			":": c = '{len: 3'd6, pat: 6'b111000};
			"-": c = '{len: 3'd6, pat: 6'b100001};
			"'": c = '{len: 3'd6, pat: 6'b011110};
			"(": c = '{len: 3'd5, pat: 6'b101100};
			")": c = '{len: 3'd6, pat: 6'b101101};
			"\"": c = '{len: 3'd6, pat: 6'b010010};
			"+": c = '{len: 3'd5, pat: 6'b010100};
			"=": c = '{len: 3'd5, pat: 6'b100010};
			"/": c = '{len: 3'd5, pat: 6'b100100};
			default: c = '{len: 3'd0, pat: 6'b000000};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/ascii_to_morse_encoder.sv
`default_nettype none

// ASCII to Morse encoder.
// The input channel (in_valid, in_ready, in_data) takes one character word
// with a start-of-text flag. The output channel (out_valid, out_ready,
// out_data) gives one Morse symbol word per handshake: dot, dash, letter gap
// or word gap, with a last flag on the final symbol of each character and the
// running symbol count of the message. The cfg channel writes the output
// capacity; it is always ready and is meant to be written while idle.
// The first symbol word of a character passes through the front register,
// the queue, the sequencer load and the output register before it can be
// taken. The sequencer loads a character and then sends its symbols, from
// none up to a gap and six code symbols, and takes no new character until it
// is through with the last one; that sequencer sets the sustained rate.
// Reset sets the capacity to 256, clears the symbol count and the word gap
// flag and empties the queue. When the receiver stalls, the output register
// holds its symbol, the sequencer waits, and the two-entry queue and the
// front register absorb up to three more characters before in_ready drops.
module ascii_to_morse_encoder import a2m_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_word_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [15:0] cfg_data
);

	// Capacity register, written straight from the config channel.
	logic [15:0] capacity_q;

	logic push_valid;
	logic push_ready;
	item_t push_item;
	logic pop_valid;
	logic pop_ready;
	item_t pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// The front folds case, looks up the code and tags each word as a space,
	// a coded character or an unknown one. Unknown words still travel so that
	// their start-of-text flag resets the message.
	a2m_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	// Short queue so the front keeps taking words while the back is busy.
	a2m_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item)
	);

	// The back owns the message state and, unless the receiver stalls, sends
	// one symbol a cycle within a character, up to a count of capacity minus one.
	a2m_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.capacity(capacity_q),
		.item_valid(pop_valid),
		.item_ready(pop_ready),
		.item(pop_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

### hdl/a2m_front.sv
`default_nettype none

module a2m_front import a2m_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_word_t in_data,
	output logic push_valid,
	input wire logic push_ready,
	output item_t push_item
);

	logic valid_s1;
	item_t item_s1;
	item_t item_d;
	code_t code_d;

	always_comb begin
		code_d = code_lookup(in_data.char_code);
		item_d.start = in_data.start_of_text;
		item_d.code = code_d;
		if (in_data.char_code == " ") begin
			item_d.kind = KIND_SPACE;
		end else if (code_d.len != 3'd0) begin
			item_d.kind = KIND_CODE;
		end else begin
			item_d.kind = KIND_NONE;
		end
	end

	assign in_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

### hdl/a2m_queue.sv
`default_nettype none

module a2m_queue import a2m_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire item_t push_item,
	output logic pop_valid,
	input wire logic pop_ready,
	output item_t pop_item
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	item_t entry_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = count_q != CNT_BITS'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### hdl/a2m_back.sv
`default_nettype none

module a2m_back import a2m_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [15:0] capacity,
	input wire logic item_valid,
	output logic item_ready,
	input wire item_t item,
	output logic out_valid,
	input wire logic out_ready,
	output out_word_t out_data
);

	localparam int CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	logic busy_q;
	logic gap_q;
	logic [1:0] gap_sym_q;
	logic [2:0] len_q;
	logic [5:0] pat_q;
	logic [COUNT_BITS-1:0] wc_q;
	logic lwg_q;
	logic out_valid_q;
	out_word_t out_q;

	logic pop;
	logic emit;
	logic [COUNT_BITS-1:0] wc_eff;
	logic lwg_eff;
	logic room_eff;
	logic gap_ok;
	logic [1:0] sym;
	logic [COUNT_BITS-1:0] wc_nx;
	logic [2:0] rem_len;
	logic more;

	// Room is left while count + 1 < capacity, which also covers capacity below two.
	function automatic logic has_room(input logic [COUNT_BITS-1:0] wc, input logic [15:0] cap);
		return (cap >= 16'd2) && ((CMP_BITS'(wc) + CMP_BITS'(1)) < CMP_BITS'(cap));
	endfunction

	assign item_ready = !busy_q;
	assign pop = item_valid && !busy_q;
	assign emit = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		wc_eff = item.start ? '0 : wc_q;
		lwg_eff = item.start ? 1'b0 : lwg_q;
		room_eff = has_room(wc_eff, capacity);
		gap_ok = (wc_eff != '0) && !lwg_eff;
		sym = gap_q ? gap_sym_q : (pat_q[5] ? SYM_DASH : SYM_DOT);
		wc_nx = wc_q + COUNT_BITS'(1);
		rem_len = gap_q ? len_q : len_q - 3'd1;
		more = (rem_len != 3'd0) && has_room(wc_nx, capacity);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			gap_q <= 1'b0;
			wc_q <= '0;
			lwg_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (item.start) begin
					wc_q <= '0;
					lwg_q <= 1'b0;
				end
				if (room_eff) begin
					case (item.kind)
						KIND_SPACE: begin
							busy_q <= gap_ok;
							gap_q <= 1'b1;
						end
						KIND_CODE: begin
							busy_q <= 1'b1;
							gap_q <= gap_ok;
						end
						default: begin
							busy_q <= 1'b0;
						end
					endcase
				end
			end else if (emit) begin
				wc_q <= wc_nx;
				lwg_q <= sym == SYM_WGAP;
				gap_q <= 1'b0;
				busy_q <= more;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && room_eff) begin
			if (item.kind == KIND_SPACE) begin
				gap_sym_q <= SYM_WGAP;
				len_q <= 3'd0;
			end else begin
				gap_sym_q <= SYM_LGAP;
				len_q <= item.code.len;
				pat_q <= item.code.pat;
			end
		end else if (emit && !gap_q) begin
			len_q <= len_q - 3'd1;
			pat_q <= {pat_q[4:0], 1'b0};
		end
		if (emit) begin
			out_q.symbol <= sym;
			out_q.last <= !more;
			out_q.symbols_written <= 16'(wc_nx);
		end
	end

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (gap_q || len_q != 3'd0))
		else $error("sequencer busy with nothing left to send");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> wc_q == COUNT_BITS'($past(wc_q) + COUNT_BITS'(1)))
		else $error("written count did not advance by one on a symbol");

	a_gap_rule: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && gap_q) |-> (!lwg_q && wc_q != '0))
		else $error("gap sent at message start or after a word gap");

endmodule

`default_nettype wire

### verif/tb_ascii_to_morse_encoder.sv
`default_nettype none

// Self-checking bench for the ASCII to Morse encoder.
//
// A driver process feeds character words from a queue that the main initial
// block fills, one phase at a time. Each accepted character word runs through
// a predictor of the encoder. The predictor appends the Morse symbol words
// that the character should cause to a queue. The monitor compares every
// accepted symbol word with the oldest entry of that queue. The capacity
// register is only written between phases, once the encoder has gone quiet.
module tb_ascii_to_morse_encoder;
	import a2m_pkg::*;

	// The encoder buffers at most three characters, so this many quiet
	// cycles after the last symbol word means that characters with no
	// symbols have drained too.
	localparam int SETTLE_CYCLES = 48;
	// The receiver holds off this long once, to fill the encoder.
	localparam int HOLD_CYCLES = 300;
	// The run is aborted after this many cycles with no handshake at all.
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	// Predictor state: the capacity register, the symbol count of the
	// current message and whether the last symbol sent was a word gap.
	logic [15:0] cap_setting = CAPACITY_RESET;
	logic [15:0] msg_count = '0;
	logic after_word_gap = 1'b0;

	in_word_t chars_to_send[$];
	out_word_t symbols_due[$];

	idle_e idle_mode = IDLE_NONE;
	bit in_took = 1'b0;
	bit hold_req = 1'b0;
	bit hold_ack = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int chars_sent = 0;
	int chars_taken = 0;
	int symbols_seen = 0;
	int cfg_writes = 0;
	int mismatches = 0;

	ascii_to_morse_encoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// International Morse code of a character as a string of dots and
	// dashes. Lower case folds to upper case; an empty string means the
	// character has no code. The plus sign is the AR prosign.
	function automatic string morse_of(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (u >= "a" && u <= "z") begin
			u = u - 8'd32;
		end
		case (u)
			"A": return ".-";
			"B": return "-...";
			"C": return "-.-.";
			"D": return "-..";
			"E": return ".";
			"F": return "..-.";
			"G": return "--.";
			"H": return "....";
			"I": return "..";
			"J": return ".---";
			"K": return "-.-";
			"L": return ".-..";
			"M": return "--";
			"N": return "-.";
			"O": return "---";
			"P": return ".--.";
			"Q": return "--.-";
			"R": return ".-.";
			"S": return "...";
			"T": return "-";
			"U": return "..-";
			"V": return "...-";
			"W": return ".--";
			"X": return "-..-";
			"Y": return "-.--";
			"Z": return "--..";
			"0": return "-----";
			"1": return ".----";
			"2": return "..---";
			"3": return "...--";
			"4": return "....-";
			"5": return ".....";
			"6": return "-....";
			"7": return "--...";
			"8": return "---..";
			"9": return "----.";
			".": return ".-.-.-";
			",": return "--..--";
			"?": return "..--..";
			"!": return "-.-.--";
			":": return "---...";
			"-": return "-....-";
			"'": return ".----.";
			"(": return "-.--.";
			")": return "-.--.-";
			"\"": return ".-..-.";
			"+": return ".-.-.";
			"=": return "-...-";
			"/": return "-..-.";
			default: return "";
		endcase
	endfunction

	// A message holds at most capacity minus one symbols, and nothing at
	// all when the capacity is below two.
	function automatic bit has_room();
		return int'(cap_setting) >= 2 && int'(msg_count) < int'(cap_setting) - 1;
	endfunction

	// Works out the symbol words of one accepted character and queues them.
	task automatic predict_symbols(input in_word_t w);
		string code;
		logic [1:0] syms [0:6];
		logic [15:0] base;
		int n;
		out_word_t o;
		n = 0;
		code = morse_of(w.char_code);
		if (w.start_of_text) begin
			msg_count = '0;
			after_word_gap = 1'b0;
		end
		base = msg_count;
		if (has_room()) begin
			if (w.char_code == " ") begin
				// One word gap between words: never at the start of a
				// message and never two in a row.
				if (msg_count != 0 && !after_word_gap) begin
					syms[n] = SYM_WGAP;
					n++;
					msg_count++;
				end
			end else if (code.len() != 0) begin
				if (msg_count != 0 && !after_word_gap) begin
					syms[n] = SYM_LGAP;
					n++;
					msg_count++;
				end
				// A character that runs into the limit is cut short.
				for (int j = 0; j < code.len() && has_room(); j++) begin
					syms[n] = (code[j] == "-") ? SYM_DASH : SYM_DOT;
					n++;
					msg_count++;
				end
			end
		end
		if (n != 0) begin
			after_word_gap = (syms[n - 1] == SYM_WGAP);
		end
		for (int k = 0; k < n; k++) begin
			o.symbol = syms[k];
			o.last = (k == n - 1);
			o.symbols_written = 16'(int'(base) + k + 1);
			symbols_due.push_back(o);
		end
	endtask

	// Random text: mostly letters, digits, marks and spaces, so that
	// messages grow long enough to meet the capacity, with some noise bytes
	// over the whole code range and an occasional start of a new message.
	function automatic in_word_t random_char();
		in_word_t w;
		string marks;
		int pick;
		marks = ".,?!:-'()\"+=/";
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			w.char_code = 8'("A") + 8'($urandom_range(0, 25));
			if ($urandom_range(0, 1) != 0) begin
				w.char_code = w.char_code + 8'd32;
			end
		end else if (pick < 60) begin
			w.char_code = 8'("0") + 8'($urandom_range(0, 9));
		end else if (pick < 72) begin
			w.char_code = marks[$urandom_range(0, 12)];
		end else if (pick < 88) begin
			w.char_code = " ";
		end else begin
			w.char_code = 8'($urandom_range(0, 255));
		end
		w.start_of_text = ($urandom_range(0, 15) == 0);
		return w;
	endfunction

	task automatic push_char(input logic [7:0] c, input logic start);
		in_word_t w;
		w.char_code = c;
		w.start_of_text = start;
		chars_to_send.push_back(w);
		chars_sent++;
	endtask

	// Waits until every character word is taken and every symbol word has
	// come, then lets characters with no symbols drain as well.
	task automatic wait_drained();
		while (chars_taken != chars_sent || symbols_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One phase of random text under one capacity and one idling pattern.
	// With a long stall asked, the receiver stops once all the text is
	// queued, while the driver keeps offering words.
	task automatic run_phase(input logic [15:0] cap, input idle_e mode, input int count,
			input bit long_stall);
		write_capacity(cap);
		idle_mode = mode;
		for (int i = 0; i < count; i++) begin
			chars_to_send.push_back(random_char());
			chars_sent++;
		end
		if (long_stall) begin
			hold_req = !hold_req;
		end
		wait_drained();
	endtask

	function automatic bit coin(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Driver: a word stays on the bus until taken; the next one goes up at
	// the falling edge after the handshake unless the sender idles.
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (chars_to_send.size() != 0 &&
					!((idle_mode == IDLE_SEND && coin(81)) ||
					(idle_mode == IDLE_BOTH && coin(13)))) begin
				in_data <= chars_to_send.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls by phase, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !((idle_mode == IDLE_RECV && coin(81)) ||
				(idle_mode == IDLE_BOTH && coin(13)));
		end
	end

	// Monitor: tracks register writes, predicts from accepted character
	// words and checks accepted symbol words in order.
	always @(posedge clk) begin
		in_took = in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cap_setting = cfg_data;
				cfg_writes++;
			end
			if (in_took) begin
				predict_symbols(in_data);
				chars_taken++;
			end
			if (out_valid && out_ready) begin
				symbols_seen++;
				if (symbols_due.size() == 0) begin
					mismatches++;
					$display("%0t: expected no symbol word, got sym %0d last %0d cnt %0d",
						$time, out_data.symbol, out_data.last,
						out_data.symbols_written);
				end else begin
					out_word_t want;
					want = symbols_due.pop_front();
					if (out_data.symbol !== want.symbol || out_data.last !== want.last ||
							out_data.symbols_written !== want.symbols_written) begin
						mismatches++;
						$display("%0t: expected sym %0d last %0d cnt %0d, got %0d %0d %0d",
							$time, want.symbol, want.last, want.symbols_written,
							out_data.symbol, out_data.last, out_data.symbols_written);
					end
				end
			end
		end
	end

	// Watchdog: any handshake restarts the count of quiet cycles.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed text at the reset capacity. A space that opens a message
		// gives nothing; the first letter has no leading gap; a second space
		// gives no second word gap; a digit after a word gap has no letter
		// gap. Then the longest codes, every punctuation mark, the plus sign,
		// bytes with no code, and a new message started midway.
		push_char(" ", 1'b1);
		push_char("a", 1'b0);
		push_char("Z", 1'b0);
		push_char(" ", 1'b0);
		push_char(" ", 1'b0);
		push_char("0", 1'b0);
		push_char("9", 1'b0);
		push_char(".", 1'b0);
		push_char("+", 1'b0);
		push_char("/", 1'b0);
		push_char("\"", 1'b0);
		push_char(8'h00, 1'b0);
		push_char(8'hff, 1'b0);
		push_char(8'h80, 1'b0);
		push_char("'", 1'b0);
		push_char("(", 1'b0);
		push_char(")", 1'b0);
		push_char(",", 1'b0);
		push_char("?", 1'b0);
		push_char("!", 1'b0);
		push_char(":", 1'b0);
		push_char("-", 1'b0);
		push_char("=", 1'b0);
		push_char("q", 1'b1);
		push_char(8'h7f, 1'b0);
		wait_drained();

		// Random phases across the capacity range, including the values at
		// which nothing or a single symbol fits, and one long output stall.
		run_phase(16'hffff, IDLE_NONE, 60, 1'b0);
		run_phase(16'd0, IDLE_SEND, 15, 1'b0);
		run_phase(16'd1, IDLE_RECV, 15, 1'b0);
		run_phase(16'd2, IDLE_BOTH, 20, 1'b0);
		run_phase(16'd9, IDLE_SEND, 50, 1'b0);
		run_phase(16'd256, IDLE_NONE, 60, 1'b1);
		// Lowering the capacity under a long message stops it at once.
		run_phase(16'($urandom_range(3, 40)), IDLE_RECV, 50, 1'b0);

		$display("Encoded %0d characters into %0d checked symbols across %0d capacity writes,",
			chars_taken, symbols_seen, cfg_writes);
		$display("with free-running, sender-idle, receiver-stall and mixed traffic.");
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire
